// ===== rtl/ils_pkg.sv =====
// Shared types, constants and helpers for the iterative linear solver.
// No dependencies.
`default_nettype none
package ils_pkg;

  localparam int MaxOrder     = 4;
  localparam int IdxW         = $clog2(MaxOrder);
  localparam int FractionBits = 16;

  localparam logic signed [63:0] SatMax   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [62:0]        RsqMax   = {63{1'b1}};
  localparam logic [63:0]        SqrtLimit = 64'd3037000499;

  localparam logic [7:0]         SweepReset = 8'd30;
  localparam logic signed [31:0] GuessReset = 32'sd655360000;
  localparam logic [2:0]         SizeReset  = 3'd3;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_SOLVE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_METHOD = 2'd0,
    CFG_SWEEPS = 2'd1,
    CFG_GUESS  = 2'd2,
    CFG_SIZE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE, S_COPY, S_ROW, S_TERM, S_MUL, S_ACC, S_DRD, S_DST, S_DIV,
    S_RROW, S_RSQ, S_RADD, S_OUT
  } state_e;

  // Saturating add, clamps to +-(2^63-1)
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SatMax;
    if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF) return -SatMax;
    return s[63:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/iterative_linear_solver.sv =====
// Iterative linear solver, Gauss-Seidel or Jacobi, Q16.16 fixed point.
// Each sweep runs a multiply-accumulate per off-diagonal term and a bit-serial
// divide per row (a zero-pivot row is skipped); a residual pass then sums the
// squared row errors, and n result requests follow. One item at a time,
// 16-entry matrix memory.
// Reset (async, low) restores register defaults and idles the sequencer.
`default_nettype none
module iterative_linear_solver import ils_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input requests
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         op_i,
  input  wire logic [1:0]         row_i,
  input  wire logic [1:0]         col_i,
  input  wire logic signed [31:0] value_i,
  // config writes
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  // results
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              index_o,
  output logic signed [31:0]      solution_o,
  output logic [62:0]             residual_sq_o,
  output logic                    divide_error_o,
  output logic                    last_o
);
  // config registers
  logic              method_q;
  logic [7:0]        sweeps_q;
  logic signed [31:0] guess_q;
  logic [2:0]        size_q;

  // matrix memory, row-major, synchronous read
  logic signed [31:0] mem [MaxOrder*MaxOrder];
  logic signed [31:0] mem_rd_q;
  logic [2*IdxW-1:0]  rd_addr;

  logic signed [31:0] rhs_q  [MaxOrder];
  logic signed [31:0] sol_q  [MaxOrder];
  logic signed [31:0] prev_q [MaxOrder];
  logic [MaxOrder-1:0] dzero_q;  // diagonal entry written as zero

  state_e            state_q, state_d;
  logic [IdxW-1:0]   i_q, j_q, nl_q;  // row, column, last index
  logic [7:0]        s_q;
  logic              resid_q;         // residual pass vs sweep
  logic              derr_q;
  logic signed [63:0] acc_q, prod_q;
  logic              big_q;
  logic [62:0]       rsq_q;

  logic              in_acc;
  logic signed [31:0] x_sel;
  logic signed [63:0] r_sh, r_abs;
  logic [63:0]       rsq_sum;
  logic              div_start, div_done;
  logic signed [31:0] div_quot;
  logic [IdxW-1:0]   nl_d;
  logic [MaxOrder-1:0] dmask;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Jacobi reads the start-of-sweep copy; residual always uses final values
  assign x_sel = (method_q && !resid_q) ? prev_q[j_q] : sol_q[j_q];
  assign r_sh  = acc_q >>> FractionBits;  // floor
  assign r_abs = r_sh[63] ? -r_sh : r_sh;
  assign rsq_sum = {1'b0, rsq_q} + prod_q;
  assign div_start = (state_q == S_DST);

  always_comb begin
    if (size_q == 3'd0)                 nl_d = '0;
    else if (size_q > 3'(MaxOrder))     nl_d = IdxW'(MaxOrder - 1);
    else                                nl_d = IdxW'(size_q - 3'd1);
    for (int k = 0; k < MaxOrder; k++) dmask[k] = (IdxW'(k) <= nl_d);
  end

  assign rd_addr = (state_q == S_DRD) ? {i_q, i_q} : {i_q, j_q};

  always_ff @(posedge clk_i) begin
    if (in_acc && op_e'(op_i) == OP_LOAD_A) mem[{row_i, col_i}] <= value_i;
    mem_rd_q <= mem[rd_addr];
  end

  ils_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (mem_rd_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= 1'b0;
      sweeps_q <= SweepReset;
      guess_q  <= GuessReset;
      size_q   <= SizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_METHOD: method_q <= cfg_data_i[0];
        CFG_SWEEPS: sweeps_q <= cfg_data_i[7:0];
        CFG_GUESS:  guess_q  <= cfg_data_i;
        CFG_SIZE:   size_q   <= cfg_data_i[2:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc && op_e'(op_i) == OP_SOLVE)
                state_d = (sweeps_q == 8'd0) ? S_RROW : S_COPY;
      S_COPY: state_d = S_ROW;
      S_ROW:  state_d = dzero_q[i_q] ? ((i_q == nl_q) ?
                ((s_q + 8'd1 == sweeps_q) ? S_RROW : S_COPY) : S_ROW) : S_TERM;
      S_TERM: state_d = (j_q == i_q && !resid_q) ? ((j_q == nl_q) ? S_DRD : S_TERM)
                                                 : S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = (j_q == nl_q) ? (resid_q ? S_RSQ : S_DRD) : S_TERM;
      S_DRD:  state_d = S_DST;
      S_DST:  state_d = S_DIV;
      S_DIV:  if (div_done)
                state_d = (i_q == nl_q) ?
                  ((s_q + 8'd1 == sweeps_q) ? S_RROW : S_COPY) : S_ROW;
      S_RROW: state_d = S_TERM;
      S_RSQ:  state_d = S_RADD;
      S_RADD: state_d = (i_q == nl_q) ? S_OUT : S_RROW;
      S_OUT:  if (!out_stall_i && i_q == nl_q) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0; j_q <= '0; nl_q <= '0; s_q <= '0;
      resid_q <= 1'b0; derr_q <= 1'b0; dzero_q <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc && op_e'(op_i) == OP_LOAD_A && row_i == col_i)
            dzero_q[row_i] <= (value_i == '0);
          if (in_acc && op_e'(op_i) == OP_SOLVE) begin
            nl_q    <= nl_d;
            derr_q  <= |(dzero_q & dmask);
            s_q     <= '0;
            i_q     <= '0;
            resid_q <= (sweeps_q == 8'd0);
          end
        end
        S_COPY: i_q <= '0;
        S_ROW: begin
          j_q <= '0;
          if (dzero_q[i_q]) begin
            if (i_q == nl_q) begin
              s_q <= s_q + 8'd1;
              i_q <= '0;
              if (s_q + 8'd1 == sweeps_q) resid_q <= 1'b1;
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
        end
        S_TERM: if (j_q == i_q && !resid_q && j_q != nl_q) j_q <= j_q + 1'b1;
        S_ACC:  if (j_q != nl_q) j_q <= j_q + 1'b1;
        S_DIV: if (div_done) begin
          if (i_q == nl_q) begin
            s_q <= s_q + 8'd1;
            i_q <= '0;
            if (s_q + 8'd1 == sweeps_q) resid_q <= 1'b1;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_RROW: j_q <= '0;
        S_RADD: i_q <= (i_q == nl_q) ? '0 : i_q + 1'b1;
        S_OUT:  if (!out_stall_i && i_q != nl_q) i_q <= i_q + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc && op_e'(op_i) == OP_LOAD_B) rhs_q[row_i] <= value_i;
        if (in_acc && op_e'(op_i) == OP_SOLVE) begin
          for (int k = 0; k < MaxOrder; k++) sol_q[k] <= guess_q;
          rsq_q <= '0;
        end
      end
      S_COPY: for (int k = 0; k < MaxOrder; k++) prev_q[k] <= sol_q[k];
      S_ROW:  acc_q <= 64'(rhs_q[i_q]) <<< FractionBits;
      S_RROW: acc_q <= -(64'(rhs_q[i_q]) <<< FractionBits);
      S_MUL:  prod_q <= mem_rd_q * x_sel;
      S_ACC:  acc_q <= sat_add(acc_q, resid_q ? prod_q : -prod_q);
      S_DIV:  if (div_done) sol_q[i_q] <= div_quot;
      S_RSQ: begin
        big_q  <= (r_abs > SqrtLimit);
        prod_q <= $signed(64'(r_abs[31:0]) * 64'(r_abs[31:0]));
      end
      S_RADD: rsq_q <= (big_q || rsq_sum > {1'b0, RsqMax}) ? RsqMax : rsq_sum[62:0];
      default: ;
    endcase
  end

  assign out_valid_o    = (state_q == S_OUT);
  assign index_o        = i_q;
  assign solution_o     = sol_q[i_q];
  assign residual_sq_o  = rsq_q;
  assign divide_error_o = derr_q;
  assign last_o         = (i_q == nl_q);
endmodule
`default_nettype wire

// ===== rtl/ils_div.sv =====
// Restoring signed divider, one quotient bit per cycle, result saturated
// to 32 bits and truncated toward zero. Depends on ils_pkg.
`default_nettype none
module ils_div import ils_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] dividend_i,
  input  wire logic signed [31:0] divisor_i,
  output logic                    done_o,
  output logic signed [31:0]      quot_o
);
  logic [5:0]  cnt_q;
  logic        busy_q, neg_q, done_q;
  logic [32:0] rem_q;
  logic [62:0] dvd_q;
  logic [31:0] dv_q;
  logic [32:0] trial;
  logic        fits;
  logic [63:0] dmag;

  assign trial = {rem_q[31:0], dvd_q[62]};
  assign fits  = trial >= {1'b0, dv_q};
  assign dmag  = dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd62;
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dmag[62:0];
      dv_q  <= divisor_i[31] ? 32'(-divisor_i) : 32'(divisor_i);
      neg_q <= dividend_i[63] ^ divisor_i[31];
    end else if (busy_q) begin
      rem_q <= fits ? trial - {1'b0, dv_q} : trial;
      dvd_q <= {dvd_q[61:0], fits};
    end
  end

  always_comb begin
    if (neg_q) begin
      quot_o = (dvd_q > 63'h8000_0000) ? 32'sh8000_0000 : 32'(-dvd_q[31:0]);
    end else begin
      quot_o = (dvd_q > 63'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dvd_q[31:0];
    end
  end

  assign done_o = done_q;
endmodule
`default_nettype wire
